### design/terminal_line_wrap_segmenter_unit_assert.svh
// Assertion macros for the line wrap segmenter checker.
`ifndef TERMINAL_LINE_WRAP_SEGMENTER_UNIT_ASSERT_SVH
`define TERMINAL_LINE_WRAP_SEGMENTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define TLWSU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TLWSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/tlwsu_pkg.sv
// Types, constants and helpers for the terminal line wrap segmenter.
`default_nettype none

package tlwsu_pkg;

   // Line limit and index widths
   localparam int unsigned MAX_LINE_CELLS = 4194304;
   localparam int unsigned IDX_W          = 23;
   localparam int unsigned COL_W          = 12;
   localparam int unsigned USED_W         = 13;
   localparam int unsigned ID_W           = 32;
   localparam int unsigned RAW_W          = 8;

   localparam logic [IDX_W-1:0] MAX_IDX     = IDX_W'(MAX_LINE_CELLS);
   localparam logic [COL_W-1:0] COLS_RESET  = COL_W'(80);
   localparam logic [1:0]       GLYPH_NARROW = 2'd1;
   localparam logic [1:0]       GLYPH_WIDE   = 2'd2;

   // One incoming cell transaction
   typedef struct packed {
      logic [ID_W-1:0]  line_id;
      logic [RAW_W-1:0] cell_width;
      logic             is_continuation;
      logic             last_cell;
      logic             empty_line;
      logic             hard_break;
   } item_type;

   // One display-row segment
   typedef struct packed {
      logic [ID_W-1:0]  line_id;
      logic [IDX_W-1:0] seg_start;
      logic [IDX_W-1:0] seg_end;
      logic [IDX_W-1:0] wrap_index;
      logic             hard_break;
      logic             last_result;
   } seg_type;

   // Up to two segments made by one cell
   typedef struct packed {
      logic [1:0] count;
      seg_type    seg0;
      seg_type    seg1;
   } batch_type;

   // Increment that sticks at the line limit
   function automatic logic [IDX_W-1:0] sat_inc(input logic [IDX_W-1:0] v);
      return (v >= MAX_IDX) ? MAX_IDX : v + IDX_W'(1);
   endfunction

endpackage

`default_nettype wire

### design/tlwsu_in_stage.sv
// Input register of the segmenter: holds one cell transaction for the core.
`default_nettype none

module tlwsu_in_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output      logic               in_ready,
   input  wire tlwsu_pkg::item_type in_item,
   output      logic               item_valid,
   output      tlwsu_pkg::item_type item,
   input  wire logic               item_take
);
   import tlwsu_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // Accept when empty or when the held cell moves on this cycle
   assign in_ready   = !valid_ff || item_take;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload on accept
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

`default_nettype wire

### design/tlwsu_core.sv
// Row-fitting core: line state, column register and segment generation.
`default_nettype none

module tlwsu_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [11:0]         csr_wdata,
   input  wire tlwsu_pkg::item_type item,
   input  wire logic                fire,
   output      tlwsu_pkg::batch_type batch
);
   import tlwsu_pkg::*;

   logic [COL_W-1:0]  columns_ff;
   logic [IDX_W-1:0]  cell_index_ff, cell_index_in;
   logic [IDX_W-1:0]  segment_begin_ff, segment_begin_in;
   logic [USED_W-1:0] used_columns_ff, used_columns_in;
   logic [IDX_W-1:0]  wrap_count_ff, wrap_count_in;
   logic              row_full_ff, row_full_in;
   logic              after_wide_ff, after_wide_in;

   logic [1:0]        glyph_w;
   logic [COL_W-1:0]  cols;
   logic [IDX_W-1:0]  idx_inc;
   logic [IDX_W-1:0]  wrap_inc;
   logic [USED_W-1:0] used_sum;
   logic              close_row;
   logic [IDX_W-1:0]  begin_post;
   logic [IDX_W-1:0]  wrap_post;
   logic [USED_W-1:0] used_post;
   logic [USED_W-1:0] used_new;
   logic              wide_cont;
   seg_type           close_seg;
   seg_type           final_seg;

   // Column register
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= COLS_RESET;
      end else if (csr_we) begin
         columns_ff <= csr_wdata;
      end
   end

   // Shared terms of the fit decision
   always_comb begin
      glyph_w    = (item.cell_width >= RAW_W'(2)) ? GLYPH_WIDE : GLYPH_NARROW;
      cols       = (columns_ff == '0) ? COL_W'(1) : columns_ff;
      idx_inc    = sat_inc(cell_index_ff);
      wrap_inc   = sat_inc(wrap_count_ff);
      used_sum   = used_columns_ff + USED_W'(glyph_w);
      wide_cont  = row_full_ff && after_wide_ff && item.is_continuation;
      close_row  = row_full_ff || (!item.is_continuation && used_columns_ff != '0 &&
                                   used_sum > USED_W'(cols));
      begin_post = close_row ? cell_index_ff : segment_begin_ff;
      wrap_post  = close_row ? wrap_inc : wrap_count_ff;
      used_post  = close_row ? '0 : used_columns_ff;
      used_new   = used_post + USED_W'(glyph_w);

      // Row closed ahead of this cell
      close_seg.line_id     = item.line_id;
      close_seg.seg_start   = segment_begin_ff;
      close_seg.seg_end     = cell_index_ff;
      close_seg.wrap_index  = wrap_count_ff;
      close_seg.hard_break  = 1'b0;
      close_seg.last_result = !item.last_cell;

      // Closing segment of the line
      final_seg.line_id     = item.line_id;
      final_seg.seg_start   = begin_post;
      final_seg.seg_end     = idx_inc;
      final_seg.wrap_index  = wrap_post;
      final_seg.hard_break  = item.hard_break;
      final_seg.last_result = 1'b1;
   end

   // Segments and next line state
   always_comb begin
      batch            = '0;
      cell_index_in    = cell_index_ff;
      segment_begin_in = segment_begin_ff;
      used_columns_in  = used_columns_ff;
      wrap_count_in    = wrap_count_ff;
      row_full_in      = row_full_ff;
      after_wide_in    = after_wide_ff;
      priority if (item.empty_line) begin
         batch.count            = 2'd1;
         batch.seg0.line_id     = item.line_id;
         batch.seg0.hard_break  = item.hard_break;
         batch.seg0.last_result = 1'b1;
         cell_index_in    = '0;
         segment_begin_in = '0;
         used_columns_in  = '0;
         wrap_count_in    = '0;
         row_full_in      = 1'b0;
         after_wide_in    = 1'b0;
      end else if (wide_cont) begin
         // absorb the second half of the wide glyph, then close the row
         batch.count            = 2'd1;
         batch.seg0.line_id     = item.line_id;
         batch.seg0.seg_start   = segment_begin_ff;
         batch.seg0.seg_end     = idx_inc;
         batch.seg0.wrap_index  = wrap_count_ff;
         batch.seg0.hard_break  = item.last_cell && item.hard_break;
         batch.seg0.last_result = 1'b1;
         row_full_in   = 1'b0;
         after_wide_in = 1'b0;
         used_columns_in = '0;
         if (item.last_cell) begin
            cell_index_in    = '0;
            segment_begin_in = '0;
            wrap_count_in    = '0;
         end else begin
            cell_index_in    = idx_inc;
            segment_begin_in = idx_inc;
            wrap_count_in    = wrap_inc;
         end
      end else begin
         // close if needed, place the cell, end the line if marked
         if (close_row && item.last_cell) begin
            batch.count = 2'd2;
            batch.seg0  = close_seg;
            batch.seg1  = final_seg;
         end else if (close_row) begin
            batch.count = 2'd1;
            batch.seg0  = close_seg;
         end else if (item.last_cell) begin
            batch.count = 2'd1;
            batch.seg0  = final_seg;
         end
         if (item.last_cell) begin
            cell_index_in    = '0;
            segment_begin_in = '0;
            used_columns_in  = '0;
            wrap_count_in    = '0;
            row_full_in      = 1'b0;
            after_wide_in    = 1'b0;
         end else begin
            cell_index_in    = idx_inc;
            segment_begin_in = begin_post;
            wrap_count_in    = wrap_post;
            if (item.is_continuation) begin
               used_columns_in = used_post;
               row_full_in     = 1'b0;
               after_wide_in   = 1'b0;
            end else begin
               used_columns_in = used_new;
               row_full_in     = used_new >= USED_W'(cols);
               after_wide_in   = glyph_w == GLYPH_WIDE;
            end
         end
      end
   end

   // Line state advances once per cell
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_index_ff    <= '0;
         segment_begin_ff <= '0;
         used_columns_ff  <= '0;
         wrap_count_ff    <= '0;
         row_full_ff      <= 1'b0;
         after_wide_ff    <= 1'b0;
      end else if (fire) begin
         cell_index_ff    <= cell_index_in;
         segment_begin_ff <= segment_begin_in;
         used_columns_ff  <= used_columns_in;
         wrap_count_ff    <= wrap_count_in;
         row_full_ff      <= row_full_in;
         after_wide_ff    <= after_wide_in;
      end
   end

endmodule

`default_nettype wire

### design/tlwsu_out_buf.sv
// Result register of the segmenter: holds up to two segments of one cell.
`default_nettype none

module tlwsu_out_buf (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tlwsu_pkg::batch_type batch,
   input  wire logic                 item_valid,
   output      logic                 fire,
   output      logic                 seg_valid,
   output      tlwsu_pkg::seg_type   seg,
   input  wire logic                 seg_ready
);
   import tlwsu_pkg::*;

   logic [1:0] count_ff, count_in;
   seg_type    slot0_ff;
   seg_type    slot1_ff;
   logic       pop;
   logic       can_load;

   assign seg_valid = count_ff != 2'd0;
   assign seg       = slot0_ff;
   assign pop       = seg_valid && seg_ready;
   assign can_load  = (count_ff == 2'd0) || (count_ff == 2'd1 && pop);
   assign fire      = item_valid && can_load;

   always_comb begin
      count_in = count_ff;
      if (fire) begin
         count_in = batch.count;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Load a new pair, or shift the second segment forward
   always_ff @(posedge clock) begin
      if (fire) begin
         slot0_ff <= batch.seg0;
         slot1_ff <= batch.seg1;
      end else if (pop) begin
         slot0_ff <= slot1_ff;
      end
   end

endmodule

`default_nettype wire

### design/terminal_line_wrap_segmenter_unit.sv
// Top level of the terminal line wrap segmenter.
// Cells of a logical line stream in one transaction per clock when the result
// port does not stall; each cell is held in an input register, fitted against
// the open row combinationally, and its zero, one or two display-row segments
// land in a result register. A cell that yields at most one segment sustains
// one transaction per clock while rsp_tready stays high; a cell that yields two
// (a row closed ahead of the line's last cell) holds up the next cell until its
// second segment is taken, since the result port delivers one segment per clock.
// The columns register may be written only while no cell is in flight.
`default_nettype none

module terminal_line_wrap_segmenter_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   // req_tdata: line_id[31:0], cell_width[39:32]
   input  wire logic [39:0]  req_tdata,
   // req_tuser: is_continuation[0], empty_line[1], hard_break[2]
   input  wire logic [2:0]   req_tuser,
   input  wire logic         req_tlast,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   // rsp_tdata: seg_line_id[31:0], seg_start[54:32], seg_end[77:55],
   //            wrap_index[100:78], zero fill[103:101]
   output      logic [103:0] rsp_tdata,
   // rsp_tuser: seg_hard_break[0]
   output      logic         rsp_tuser,
   output      logic         rsp_tlast,
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic         csr_we,
   input  wire logic [11:0]  csr_wdata
);
   import tlwsu_pkg::*;

   item_type  in_item;
   item_type  item;
   logic      item_valid;
   logic      fire;
   batch_type batch;
   seg_type   seg;

   // Unpack the request transaction
   always_comb begin
      in_item.line_id         = req_tdata[31:0];
      in_item.cell_width      = req_tdata[39:32];
      in_item.is_continuation = req_tuser[0];
      in_item.empty_line      = req_tuser[1];
      in_item.hard_break      = req_tuser[2];
      in_item.last_cell       = req_tlast;
   end

   tlwsu_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (fire)
   );

   tlwsu_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .item      (item),
      .fire      (fire),
      .batch     (batch)
   );

   tlwsu_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .batch      (batch),
      .item_valid (item_valid),
      .fire       (fire),
      .seg_valid  (rsp_tvalid),
      .seg        (seg),
      .seg_ready  (rsp_tready)
   );

   // Pack the response transaction
   assign rsp_tdata = {3'b000, seg.wrap_index, seg.seg_end, seg.seg_start, seg.line_id};
   assign rsp_tuser = seg.hard_break;
   assign rsp_tlast = seg.last_result;

endmodule

`default_nettype wire

### design/tlwsu_checker.sv
// Port-level checker for the terminal line wrap segmenter, with its bind.
`default_nettype none

`include "terminal_line_wrap_segmenter_unit_assert.svh"

module tlwsu_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic [39:0]  req_tdata,
   input wire logic [2:0]   req_tuser,
   input wire logic         req_tlast,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic [103:0] rsp_tdata,
   input wire logic         rsp_tuser,
   input wire logic         rsp_tlast,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic         csr_we,
   input wire logic [11:0]  csr_wdata
);

   // Stalled response holds its data and last flag
   `TLWSU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "response changed while stalled")

   // Hard break only on the last segment of a cell
   `TLWSU_ASSERT_NOW(a_hb_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast, "hard break on a non-final segment")

   // Segment never ends before it starts
   `TLWSU_ASSERT_NOW(a_seg_order, clock, reset, rsp_tvalid, rsp_tdata[77:55] >= rsp_tdata[54:32], "segment end below segment start")

   // A non-final segment is followed by its partner
   `TLWSU_ASSERT_NEXT(a_pair_follow, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tvalid, "second segment of a cell missing")

endmodule

bind terminal_line_wrap_segmenter_unit tlwsu_checker u_tlwsu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .req_tlast  (req_tlast),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .csr_we     (csr_we),
   .csr_wdata  (csr_wdata)
);

`default_nettype wire
